// File: rtl/core/sdf_band_nearest_face_search_assert.svh
// Assertion helpers for the block's controller.
// Each expects clk and arst_n in scope.
`ifndef SDF_BAND_NEAREST_FACE_SEARCH_ASSERT_SVH
`define SDF_BAND_NEAREST_FACE_SEARCH_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent
`define SBNF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define SBNF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/sbnf_pkg.sv
`timescale 1ns / 1ps
package sbnf_pkg;

	// Face store size
	localparam int MAX_FACES = 1024;
	localparam int ADDR_W    = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;
	localparam int CNT_W     = $clog2(MAX_FACES + 1);

	// Field widths
	localparam int COORD_W = 24;
	localparam int GID_W   = 24;
	localparam int VOX_W   = 8;
	localparam int SDF_W   = 16;
	localparam int SCALE_W = 16;
	localparam int BAND_W  = 31;
	localparam int CLS_W   = 2;

	// Datapath widths
	localparam int PHYS_W = SDF_W + SCALE_W + 1;
	localparam int P_W    = COORD_W + 1;
	localparam int DIFF_W = COORD_W + 2;
	localparam int MAG_W  = DIFF_W - 1;
	localparam int SQ_W   = 2 * MAG_W;
	localparam int D2_W   = SQ_W + 2;

	// Request kinds
	localparam logic REQ_FACE  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Voxel classes
	localparam logic [CLS_W-1:0] CLS_INSIDE  = 2'd0;
	localparam logic [CLS_W-1:0] CLS_OUTSIDE = 2'd1;
	localparam logic [CLS_W-1:0] CLS_FACE    = 2'd2;
	localparam logic [CLS_W-1:0] CLS_NOFACE  = 2'd3;

	// Register map
	localparam int REG_IDX_W = 3;
	localparam int REG_DAT_W = 32;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCALE    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BAND     = 3'd4;

	typedef struct packed {
		logic [COORD_W-1:0] origin_x;
		logic [COORD_W-1:0] origin_y;
		logic [COORD_W-1:0] origin_z;
		logic [SCALE_W-1:0] sdf_scale;
		logic [BAND_W-1:0]  band_half_width;
	} cfg_t;

	// Controller to datapath
	typedef struct packed {
		logic load_face;
		logic capture;
		logic classify;
		logic issue;
		logic finish;
	} dp_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic interior;
		logic outside;
		logic empty;
		logic last_issue;
		logic pipe_busy;
	} dp_stat_t;

endpackage

// File: rtl/core/sbnf_ctrl.sv
`timescale 1ns / 1ps
module sbnf_ctrl import sbnf_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  logic     in_req_type,
	output logic     in_ready,
	input  logic     out_busy,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_CLASS = 3'd1;
	localparam logic [2:0] ST_SCAN  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_nxt;
	logic       accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Commands
	always_comb begin
		cmd.load_face = accept && (in_req_type == REQ_FACE);
		cmd.capture   = accept && (in_req_type == REQ_QUERY);
		cmd.classify  = (state_q == ST_CLASS);
		cmd.issue     = (state_q == ST_SCAN);
		cmd.finish    = (state_q == ST_DONE) && !out_busy;
	end

	// Next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd.capture) state_nxt = ST_CLASS;
			end
			ST_CLASS: begin
				if (stat.interior || stat.outside || stat.empty) state_nxt = ST_DONE;
				else state_nxt = ST_SCAN;
			end
			ST_SCAN: begin
				if (stat.last_issue) state_nxt = ST_DRAIN;
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) state_nxt = ST_DONE;
			end
			ST_DONE: begin
				if (!out_busy) state_nxt = ST_IDLE;
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_nxt;
	end

`include "sdf_band_nearest_face_search_assert.svh"

	`SBNF_ASSERT_NEXT(a_query_to_class, cmd.capture, state_q == ST_CLASS, "query not classified")
	`SBNF_ASSERT_NOW(a_issue_nonempty, cmd.issue, !stat.empty, "scan of an empty face list")
	`SBNF_ASSERT_NEXT(a_drain_done, (state_q == ST_DRAIN) && !stat.pipe_busy, state_q == ST_DONE, "drain did not finish")
	`SBNF_ASSERT_NEXT(a_done_holds, (state_q == ST_DONE) && out_busy, state_q == ST_DONE, "result lost while output stalled")

endmodule

// File: rtl/core/sbnf_dp.sv
`timescale 1ns / 1ps
module sbnf_dp import sbnf_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               first_face,
	input  logic [COORD_W-1:0] face_x,
	input  logic [COORD_W-1:0] face_y,
	input  logic [COORD_W-1:0] face_z,
	input  logic [GID_W-1:0]   face_gid,
	input  logic [VOX_W-1:0]   voxel_x,
	input  logic [VOX_W-1:0]   voxel_y,
	input  logic [VOX_W-1:0]   voxel_z,
	input  logic [SDF_W-1:0]   sdf_value,
	output logic [CLS_W-1:0]   res_class,
	output logic [GID_W-1:0]   res_gid,
	output logic               res_overflow
);

	typedef struct packed {
		logic [GID_W-1:0]   gid;
		logic [COORD_W-1:0] z;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] x;
	} face_t;

	// |p - f| per axis; fits MAG_W for all legal p and f
	function automatic logic [MAG_W-1:0] abs_diff(logic signed [P_W-1:0] p,
			logic [COORD_W-1:0] f);
		logic signed [DIFF_W-1:0] d;
		d = DIFF_W'(p) - DIFF_W'($signed(f));
		return d[DIFF_W-1] ? MAG_W'(-d) : MAG_W'(d);
	endfunction

	face_t face_mem [MAX_FACES];

	logic [CNT_W-1:0]  face_count_q;
	logic              overflow_q;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;

	// Face list bookkeeping
	assign wr_en   = cmd.load_face && (first_face || (face_count_q < CNT_W'(MAX_FACES)));
	assign wr_addr = first_face ? '0 : face_count_q[ADDR_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_count_q <= '0;
			overflow_q   <= 1'b0;
		end else if (cmd.load_face) begin
			if (first_face) begin
				face_count_q <= CNT_W'(1);
				overflow_q   <= 1'b0;
			end else if (face_count_q < CNT_W'(MAX_FACES)) begin
				face_count_q <= face_count_q + CNT_W'(1);
			end else begin
				overflow_q <= 1'b1;
			end
		end
	end

	// Query capture
	logic [VOX_W-1:0] vox_x_q, vox_y_q, vox_z_q;
	logic signed [SDF_W-1:0] sdf_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			vox_x_q <= voxel_x;
			vox_y_q <= voxel_y;
			vox_z_q <= voxel_z;
			sdf_q   <= $signed(sdf_value);
		end
	end

	// Band test on the scaled distance
	logic signed [PHYS_W-1:0] phys;
	logic signed [PHYS_W:0]   phys_e;
	logic signed [PHYS_W:0]   band_e;
	logic                     is_inside;
	logic                     is_outside;

	assign phys       = PHYS_W'(sdf_q) * PHYS_W'($signed({1'b0, cfg.sdf_scale}));
	assign phys_e     = (PHYS_W + 1)'(phys);
	assign band_e     = $signed((PHYS_W + 1)'(cfg.band_half_width));
	assign is_inside  = (phys_e <= -band_e);
	assign is_outside = !is_inside && (phys_e >= band_e);

	// Query point in grid space, Q16.8
	logic signed [P_W-1:0] p_x_q, p_y_q, p_z_q;
	logic                  inside_q, outside_q;

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			p_x_q     <= P_W'($signed({1'b0, vox_x_q, 8'b0})) + P_W'($signed(cfg.origin_x));
			p_y_q     <= P_W'($signed({1'b0, vox_y_q, 8'b0})) + P_W'($signed(cfg.origin_y));
			p_z_q     <= P_W'($signed({1'b0, vox_z_q, 8'b0})) + P_W'($signed(cfg.origin_z));
			inside_q  <= is_inside;
			outside_q <= is_outside;
		end
	end

	// Scan address
	logic [ADDR_W-1:0] addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) addr_q <= '0;
		else if (cmd.classify) addr_q <= '0;
		else if (cmd.issue) addr_q <= addr_q + ADDR_W'(1);
	end

	// Store write and registered read
	face_t rd_s1;

	always_ff @(posedge clk) begin
		if (wr_en) face_mem[wr_addr] <= '{gid: face_gid, z: face_z, y: face_y, x: face_x};
		if (cmd.issue) rd_s1 <= face_mem[addr_q];
	end

	// Distance pipeline: abs diff, square, sum
	logic v_s1, v_s2, v_s3, v_s4;
	logic [MAG_W-1:0] mag_x_s2, mag_y_s2, mag_z_s2;
	logic [GID_W-1:0] gid_s2, gid_s3, gid_s4;
	logic [SQ_W-1:0]  sq_x_s3, sq_y_s3, sq_z_s3;
	logic [D2_W-1:0]  d2_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		mag_x_s2 <= abs_diff(p_x_q, rd_s1.x);
		mag_y_s2 <= abs_diff(p_y_q, rd_s1.y);
		mag_z_s2 <= abs_diff(p_z_q, rd_s1.z);
		gid_s2   <= rd_s1.gid;
		sq_x_s3  <= SQ_W'(mag_x_s2) * SQ_W'(mag_x_s2);
		sq_y_s3  <= SQ_W'(mag_y_s2) * SQ_W'(mag_y_s2);
		sq_z_s3  <= SQ_W'(mag_z_s2) * SQ_W'(mag_z_s2);
		gid_s3   <= gid_s2;
		d2_s4    <= D2_W'(sq_x_s3) + D2_W'(sq_y_s3) + D2_W'(sq_z_s3);
		gid_s4   <= gid_s3;
	end

	// Running minimum; strict less keeps the earliest face on ties
	logic             found_q;
	logic [D2_W-1:0]  best_q;
	logic [GID_W-1:0] gid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (cmd.classify) begin
			found_q <= 1'b0;
		end else if (v_s4 && (!found_q || (d2_s4 < best_q))) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.classify) begin
			gid_q <= '0;
		end else if (v_s4 && (!found_q || (d2_s4 < best_q))) begin
			best_q <= d2_s4;
			gid_q  <= gid_s4;
		end
	end

	// Status
	always_comb begin
		stat.interior   = is_inside;
		stat.outside    = is_outside;
		stat.empty      = (face_count_q == '0);
		stat.last_issue = (CNT_W'(addr_q) == (face_count_q - CNT_W'(1)));
		stat.pipe_busy  = v_s1 || v_s2 || v_s3 || v_s4;
	end

	// Result word
	always_comb begin
		if (inside_q) res_class = CLS_INSIDE;
		else if (outside_q) res_class = CLS_OUTSIDE;
		else if (found_q) res_class = CLS_FACE;
		else res_class = CLS_NOFACE;
	end

	assign res_gid      = gid_q;
	assign res_overflow = overflow_q;

endmodule

// File: rtl/core/sdf_band_nearest_face_search.sv
`timescale 1ns / 1ps
// Nearest-face search for voxels in a signed distance band. A face-load word
// (tuser req_type 0) appends a face centre and id to a 1024-entry store;
// first_face restarts the list, and faces past capacity are dropped and
// reported through face_overflow. A query word (req_type 1) is classed inside,
// outside or in the band from sdf_value times sdf_scale against band_half_width.
// A band query scans the store through its single read port, one face per
// cycle, followed by a four-stage distance pipeline. Output stalls delay the
// result of any query.
// One word is processed at a time; a finished result waits in the output
// register while the next input word is already taken. The store needs no
// clearing after reset.
module sdf_band_nearest_face_search import sbnf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	// face_x, face_y, face_z, face_gid, voxel_x, voxel_y, voxel_z, sdf_value
	input  logic [135:0]         s_axis_tdata,
	// req_type, first_face
	input  logic [1:0]           s_axis_tuser,
	// Result stream
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	// nearest_gid
	output logic [23:0]          m_axis_tdata,
	// voxel_class[1:0], face_overflow
	output logic [2:0]           m_axis_tuser,
	// Register writes
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [REG_IDX_W-1:0] cfg_index,
	input  logic [REG_DAT_W-1:0] cfg_data
);

	// Configuration registers
	cfg_t cfg_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.origin_x        <= '0;
			cfg_q.origin_y        <= '0;
			cfg_q.origin_z        <= '0;
			cfg_q.sdf_scale       <= SCALE_W'(256);
			cfg_q.band_half_width <= BAND_W'(8388608);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ORIGIN_X: cfg_q.origin_x        <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Y: cfg_q.origin_y        <= cfg_data[COORD_W-1:0];
				REG_ORIGIN_Z: cfg_q.origin_z        <= cfg_data[COORD_W-1:0];
				REG_SCALE:    cfg_q.sdf_scale       <= cfg_data[SCALE_W-1:0];
				REG_BAND:     cfg_q.band_half_width <= cfg_data[BAND_W-1:0];
				default: ;
			endcase
		end
	end

	dp_cmd_t          cmd;
	dp_stat_t         stat;
	logic             out_busy;
	logic [CLS_W-1:0] res_class;
	logic [GID_W-1:0] res_gid;
	logic             res_overflow;

	assign out_busy = m_axis_tvalid && !m_axis_tready;

	sbnf_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_axis_tvalid),
		.in_req_type (s_axis_tuser[0]),
		.in_ready    (s_axis_tready),
		.out_busy    (out_busy),
		.stat        (stat),
		.cmd         (cmd)
	);

	sbnf_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.cmd          (cmd),
		.stat         (stat),
		.first_face   (s_axis_tuser[1]),
		.face_x       (s_axis_tdata[23:0]),
		.face_y       (s_axis_tdata[47:24]),
		.face_z       (s_axis_tdata[71:48]),
		.face_gid     (s_axis_tdata[95:72]),
		.voxel_x      (s_axis_tdata[103:96]),
		.voxel_y      (s_axis_tdata[111:104]),
		.voxel_z      (s_axis_tdata[119:112]),
		.sdf_value    (s_axis_tdata[135:120]),
		.res_class    (res_class),
		.res_gid      (res_gid),
		.res_overflow (res_overflow)
	);

	// Output register
	logic             out_valid_q;
	logic [GID_W-1:0] out_gid_q;
	logic [CLS_W-1:0] out_class_q;
	logic             out_ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (m_axis_tready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_gid_q   <= res_gid;
			out_class_q <= res_class;
			out_ovf_q   <= res_overflow;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_gid_q;
	assign m_axis_tuser  = {out_ovf_q, out_class_q};

endmodule

// File: test/tb_sdf_band_nearest_face_search.sv
`timescale 1ns / 1ps
module tb_sdf_band_nearest_face_search;
	import sbnf_pkg::*;

	localparam int SETTLE_CYCLES = 16;
	localparam int TAIL_CYCLES   = 40;
	localparam int RAND_PHASES   = 8;
	localparam int FACE_LIMIT    = 40;
	localparam int REPORT_MAX    = 10;

	localparam logic signed [COORD_W-1:0] CX_MAX = 24'sh7FFFFF;
	localparam logic signed [COORD_W-1:0] CX_MIN = -24'sh800000;
	localparam logic [BAND_W-1:0]         BAND_MAX = 31'h7FFFFFFF;
	localparam logic [REG_IDX_W-1:0]      REG_UNMAPPED = 3'd7;

	typedef struct packed {
		logic [CLS_W-1:0] cls;
		logic [GID_W-1:0] gid;
		logic             ovf;
	} voxel_result_t;

	typedef struct {
		logic                      req;
		logic                      first;
		logic signed [COORD_W-1:0] fx;
		logic signed [COORD_W-1:0] fy;
		logic signed [COORD_W-1:0] fz;
		logic [GID_W-1:0]          gid;
		logic [VOX_W-1:0]          vx;
		logic [VOX_W-1:0]          vy;
		logic [VOX_W-1:0]          vz;
		logic signed [SDF_W-1:0]   sdf;
	} stream_item_t;

	typedef struct {
		stream_item_t  item;
		bit            typed;
		voxel_result_t want;
	} directed_row_t;

	typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_HOLD} rx_mode_e;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [135:0]         s_axis_tdata;
	logic [1:0]           s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [23:0]          m_axis_tdata;
	logic [2:0]           m_axis_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [REG_DAT_W-1:0] cfg_data;

	// Shadow of the block's registers and face store
	logic signed [COORD_W-1:0] org_x, org_y, org_z;
	logic [SCALE_W-1:0]        scale;
	logic [BAND_W-1:0]         band;
	logic signed [COORD_W-1:0] store_x [MAX_FACES];
	logic signed [COORD_W-1:0] store_y [MAX_FACES];
	logic signed [COORD_W-1:0] store_z [MAX_FACES];
	logic [GID_W-1:0]          store_gid [MAX_FACES];
	int                        face_total;
	bit                        faces_dropped;

	voxel_result_t expected_results[$];
	voxel_result_t head_result;
	int            mismatches;
	int            burst_left;
	rx_mode_e      stall_mode;
	int            stretch_left;

	sdf_band_nearest_face_search i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// Append a face, restarting the list on first_face
	function automatic void store_face(stream_item_t it);
		if (it.first) begin
			face_total    = 0;
			faces_dropped = 0;
		end
		if (face_total < MAX_FACES) begin
			store_x[face_total]   = it.fx;
			store_y[face_total]   = it.fy;
			store_z[face_total]   = it.fz;
			store_gid[face_total] = it.gid;
			face_total++;
		end else begin
			faces_dropped = 1;
		end
	endfunction

	// Class of a queried voxel and its nearest face (first stored wins ties)
	function automatic voxel_result_t classify_voxel(stream_item_t it);
		voxel_result_t r;
		longint        phys, lim, px, py, pz, dx, dy, dz, d2, best;
		bit            found;
		r.gid = '0;
		r.ovf = faces_dropped;
		phys  = longint'(it.sdf) * longint'(scale);
		lim   = longint'(band);
		if (phys <= -lim) begin
			r.cls = CLS_INSIDE;
		end else if (phys >= lim) begin
			r.cls = CLS_OUTSIDE;
		end else begin
			px    = longint'(it.vx) * 256 + longint'(org_x);
			py    = longint'(it.vy) * 256 + longint'(org_y);
			pz    = longint'(it.vz) * 256 + longint'(org_z);
			found = 0;
			best  = 0;
			for (int i = 0; i < face_total; i++) begin
				dx = px - longint'(store_x[i]);
				dy = py - longint'(store_y[i]);
				dz = pz - longint'(store_z[i]);
				d2 = dx * dx + dy * dy + dz * dz;
				if (!found || d2 < best) begin
					found = 1;
					best  = d2;
					r.gid = store_gid[i];
				end
			end
			r.cls = found ? CLS_FACE : CLS_NOFACE;
		end
		return r;
	endfunction

	// Random face: full range, near the voxel grid, or a copy of a stored centre
	function automatic stream_item_t random_face(bit first);
		stream_item_t it;
		int           k;
		int           mode;
		it.req   = REQ_FACE;
		it.first = first;
		it.gid   = GID_W'($urandom);
		it.vx    = VOX_W'($urandom);
		it.vy    = VOX_W'($urandom);
		it.vz    = VOX_W'($urandom);
		it.sdf   = SDF_W'($urandom);
		mode     = $urandom_range(0, 3);
		if (mode == 3 && face_total > 0 && !first) begin
			k     = $urandom_range(0, face_total - 1);
			it.fx = store_x[k];
			it.fy = store_y[k];
			it.fz = store_z[k];
		end else if (mode == 0) begin
			it.fx = COORD_W'($urandom);
			it.fy = COORD_W'($urandom);
			it.fz = COORD_W'($urandom);
		end else begin
			it.fx = COORD_W'(int'(org_x) + int'($urandom_range(0, 255)) * 256
				+ int'($urandom_range(0, 128)) - 64);
			it.fy = COORD_W'(int'(org_y) + int'($urandom_range(0, 255)) * 256
				+ int'($urandom_range(0, 128)) - 64);
			it.fz = COORD_W'(int'(org_z) + int'($urandom_range(0, 255)) * 256
				+ int'($urandom_range(0, 128)) - 64);
		end
		return it;
	endfunction

	// Random query; sdf is full range, near the band edge, or small
	function automatic stream_item_t random_query();
		stream_item_t it;
		int           lim, s, mode;
		it.req   = REQ_QUERY;
		it.first = 1'($urandom_range(0, 1));
		it.fx    = COORD_W'($urandom);
		it.fy    = COORD_W'($urandom);
		it.fz    = COORD_W'($urandom);
		it.gid   = GID_W'($urandom);
		it.vx    = VOX_W'($urandom);
		it.vy    = VOX_W'($urandom);
		it.vz    = VOX_W'($urandom);
		mode     = $urandom_range(0, 2);
		s        = int'($urandom_range(0, 65535)) - 32768;
		if (mode == 1 && scale != 0) begin
			lim = int'(band / scale);
			s   = lim + int'($urandom_range(0, 2)) - 1;
			if ($urandom_range(0, 1))
				s = -s;
			if (s > 32767)
				s = 32767;
			if (s < -32768)
				s = -32768;
		end else if (mode == 2) begin
			s = int'($urandom_range(0, 64)) - 32;
		end
		it.sdf = SDF_W'(s);
		return it;
	endfunction

	function automatic directed_row_t drow(logic req, logic first,
		logic signed [COORD_W-1:0] fx, logic signed [COORD_W-1:0] fy,
		logic signed [COORD_W-1:0] fz, logic [GID_W-1:0] gid,
		logic [VOX_W-1:0] vx, logic [VOX_W-1:0] vy, logic [VOX_W-1:0] vz,
		logic signed [SDF_W-1:0] sdf, bit typed, logic [CLS_W-1:0] cls,
		logic [GID_W-1:0] ngid, logic ovf);
		directed_row_t r;
		r.item.req   = req;
		r.item.first = first;
		r.item.fx    = fx;
		r.item.fy    = fy;
		r.item.fz    = fz;
		r.item.gid   = gid;
		r.item.vx    = vx;
		r.item.vy    = vy;
		r.item.vz    = vz;
		r.item.sdf   = sdf;
		r.typed      = typed;
		r.want.cls   = cls;
		r.want.gid   = ngid;
		r.want.ovf   = ovf;
		return r;
	endfunction

	// Send one input word in bursts with random gaps; predict on acceptance
	task automatic send_item(stream_item_t it, bit typed, voxel_result_t want);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			gap        = $urandom_range(0, 1) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {it.sdf, it.vz, it.vy, it.vx, it.gid, it.fz, it.fy, it.fx};
		s_axis_tuser  <= {it.first, it.req};
		do @(posedge clk); while (!s_axis_tready);
		if (it.req == REQ_FACE)
			store_face(it);
		else
			expected_results.insert(expected_results.size(),
				typed ? want : classify_voxel(it));
	endtask

	// Drain all results, then let a trailing face load finish
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write every register back to back, optionally an unmapped index too
	task automatic write_settings(logic signed [COORD_W-1:0] ox,
		logic signed [COORD_W-1:0] oy, logic signed [COORD_W-1:0] oz,
		logic [SCALE_W-1:0] sc, logic [BAND_W-1:0] bw, bit poke_unmapped);
		logic [REG_IDX_W-1:0] idx [6];
		logic [REG_DAT_W-1:0] val [6];
		int                   n;
		idx[0] = REG_ORIGIN_X;  val[0] = {8'($urandom), ox};
		idx[1] = REG_ORIGIN_Y;  val[1] = {8'($urandom), oy};
		idx[2] = REG_ORIGIN_Z;  val[2] = {8'($urandom), oz};
		idx[3] = REG_SCALE;     val[3] = {16'($urandom), sc};
		idx[4] = REG_BAND;      val[4] = {1'($urandom), bw};
		idx[5] = REG_UNMAPPED;  val[5] = $urandom;
		n = poke_unmapped ? 6 : 5;
		cfg_valid <= 1'b1;
		for (int i = 0; i < n; i++) begin
			cfg_index <= idx[i];
			cfg_data  <= val[i];
			do @(posedge clk); while (!cfg_ready);
		end
		cfg_valid <= 1'b0;
		org_x = ox;
		org_y = oy;
		org_z = oz;
		scale = sc;
		band  = bw;
	endtask

	// Restart the list, then mostly queries with some appends and restarts
	task automatic run_phase(int n_items);
		int pick;
		send_item(random_face(1'b1), 1'b0, '0);
		repeat ($urandom_range(0, 13))
			send_item(random_face(1'b0), 1'b0, '0);
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(0, 99);
			if (face_total >= FACE_LIMIT || pick < 4)
				send_item(random_face(1'b1), 1'b0, '0);
			else if (pick < 30)
				send_item(random_face(1'b0), 1'b0, '0);
			else
				send_item(random_query(), 1'b0, '0);
		end
	endtask

	// Receiver stalls in stretches of differing density
	always @(posedge clk) begin
		if (stretch_left == 0) begin
			stall_mode   = rx_mode_e'($urandom_range(0, 3));
			stretch_left = (stall_mode == RX_HOLD) ? $urandom_range(1, 12)
				: $urandom_range(1, 40);
		end
		stretch_left--;
		case (stall_mode)
			RX_OPEN:   m_axis_tready <= 1'b1;
			RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
			RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
			default:   m_axis_tready <= 1'b0;
		endcase
	end

	// Compare each result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("%0t: result word with none expected: class %0d gid %h ovf %b",
						$realtime, m_axis_tuser[1:0], m_axis_tdata, m_axis_tuser[2]);
			end else begin
				head_result = expected_results.pop_front();
				if (m_axis_tuser[1:0] !== head_result.cls || m_axis_tdata !== head_result.gid
					|| m_axis_tuser[2] !== head_result.ovf) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: result mismatch: class %0d/%0d gid %h/%h ovf %b/%b (exp/act)",
							$realtime, head_result.cls, m_axis_tuser[1:0], head_result.gid,
							m_axis_tdata, head_result.ovf, m_axis_tuser[2]);
				end
			end
		end
	end

	initial begin
		directed_row_t                 rows[$];
		logic signed [COORD_W-1:0]     ox, oy, oz;
		logic [SCALE_W-1:0]            sc;
		logic [BAND_W-1:0]             bw;

		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		m_axis_tready <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= '0;
		cfg_data      <= '0;
		mismatches    = 0;
		burst_left    = 0;
		stretch_left  = 0;
		stall_mode    = RX_OPEN;
		org_x         = '0;
		org_y         = '0;
		org_z         = '0;
		scale         = 16'd256;
		band          = 31'd8388608;
		face_total    = 0;
		faces_dropped = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words at reset settings; unused fields carry junk
		// empty list: band voxel has no face
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, -1, -1, -1, '1, 0, 0, 0, 0,
			1, CLS_NOFACE, 0, 0));
		// most negative sdf lands exactly on minus the band: inside
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 0, 0, 0, -16'sd32768,
			1, CLS_INSIDE, 0, 0));
		// most positive sdf stays just inside the band
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 255, 255, 255,
			16'sd32767, 1, CLS_NOFACE, 0, 0));
		rows.insert(rows.size(), drow(REQ_FACE, 1'b1, CX_MAX, CX_MIN, 0, 24'hFFFFFF,
			255, 255, 255, 16'sh7FFF, 0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_FACE, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0,
			0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_FACE, 1'b0, CX_MIN, CX_MAX, CX_MIN, 1, 17, 0, 99,
			-16'sd1, 0, CLS_INSIDE, 0, 0));
		// voxel on the origin hits the face at zero
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, CX_MAX, CX_MAX, CX_MAX, '1,
			0, 0, 0, 0, 1, CLS_FACE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 255, 255, 255,
			-16'sd1, 0, CLS_INSIDE, 0, 0));
		// same centre again: the earlier face keeps the tie
		rows.insert(rows.size(), drow(REQ_FACE, 1'b0, 0, 0, 0, 24'h00ABCD, 0, 0, 0, 0,
			0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 0, 0, 0, 16'sd1,
			1, CLS_FACE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 255, 0, 0, 16'sd32767,
			0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 0, 255, 0, -16'sd32767,
			0, CLS_INSIDE, 0, 0));
		// restart leaves a single face
		rows.insert(rows.size(), drow(REQ_FACE, 1'b1, 24'sh000100, 0, 0, 5, 3, 3, 3,
			16'sd5, 0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 0, 0, 0, 0,
			1, CLS_FACE, 5, 0));
		// first_face on a query does nothing
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b1, -1, -1, -1, '1, 255, 255, 255, 0,
			1, CLS_FACE, 5, 0));
		rows.insert(rows.size(), drow(REQ_FACE, 1'b0, CX_MAX, CX_MAX, CX_MAX, 24'h800000,
			0, 0, 0, 0, 0, CLS_INSIDE, 0, 0));
		rows.insert(rows.size(), drow(REQ_QUERY, 1'b0, 0, 0, 0, 0, 255, 255, 255, 0,
			0, CLS_INSIDE, 0, 0));
		foreach (rows[i])
			send_item(rows[i].item, rows[i].typed, rows[i].want);
		wait_idle();

		// Random phases, each under its own register settings
		for (int p = 1; p <= RAND_PHASES; p++) begin
			ox = COORD_W'($urandom);
			oy = COORD_W'($urandom);
			oz = COORD_W'($urandom);
			sc = SCALE_W'($urandom);
			bw = $urandom_range(0, 1) ? BAND_W'($urandom)
				: BAND_W'(sc * $urandom_range(0, 32768));
			case (p)
				1: begin
					// zero band: every voxel is inside or outside
					ox = CX_MAX; oy = CX_MAX; oz = CX_MAX;
					sc = '1;     bw = '0;
				end
				2: begin
					// zero scale: every voxel lies in the band
					ox = CX_MIN; oy = CX_MIN; oz = CX_MIN;
					sc = '0;     bw = BAND_MAX;
				end
				3: begin
					ox = '0; oy = '0; oz = '0;
					sc = 16'd256; bw = 31'd8388608;
				end
				4: begin
					sc = 16'd1; bw = 31'd1;
				end
				default: ;
			endcase
			write_settings(ox, oy, oz, sc, bw, p == 1);
			run_phase($urandom_range(55, 75));
			wait_idle();
		end
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/sbnf_pkg.sv
rtl/core/sbnf_ctrl.sv
rtl/core/sbnf_dp.sv
rtl/core/sdf_band_nearest_face_search.sv
test/tb_sdf_band_nearest_face_search.sv
